// File: src/assert_macros.svh
// Assertion macros used by the debounce unit's top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication check failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// File: src/bdlp_pkg.sv
// Types and constants of the button debounce and long-press unit
package bdlp_pkg;

	localparam int BUTTON_COUNT = 16;
	localparam int ADDR_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int IDX_W = 4;
	localparam int TIME_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 8;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 1'b0,
		REG_LONG_PRESS = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;

	// Event codes
	typedef enum logic [1:0] {
		ACT_PRESSED  = 2'd0,
		ACT_LONG     = 2'd1,
		ACT_RELEASED = 2'd2
	} action_t;

	// Per-button state kept in the state memory
	typedef struct packed {
		logic              debounced;
		logic              last_raw;
		logic [TIME_W-1:0] last_change;
		logic [TIME_W-1:0] press_start;
		logic              long_rep;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		debounced:   1'b0,
		last_raw:    1'b1,
		last_change: '0,
		press_start: '0,
		long_rep:    1'b0
	};

	// Event produced by one sample
	typedef struct packed {
		logic    valid;
		action_t action;
	} event_t;

endpackage

// File: src/bdlp_state_ram.sv
// Per-button state memory with valid bits and write-to-read forwarding
module bdlp_state_ram
	import bdlp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	output entry_t            rd_data
);

	entry_t mem [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] valid_q;
	entry_t rd_q;
	logic rd_valid_q;
	logic fwd;

	assign fwd = wr_en && (wr_addr == rd_addr);

	// Write the updated entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Read with bypass of a write landing in the same cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (fwd) begin
				rd_q       <= wr_data;
				rd_valid_q <= 1'b1;
			end else begin
				rd_q       <= mem[rd_addr];
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// An entry never written reads as its reset value
	assign rd_data = rd_valid_q ? rd_q : ENTRY_RESET;

endmodule

// File: src/bdlp_update.sv
// Debounce and long-press update of one button's state entry
module bdlp_update
	import bdlp_pkg::*;
(
	input  entry_t            cur,
	input  logic              raw_pressed,
	input  logic [TIME_W-1:0] now_ms,
	input  logic [CFG_W-1:0]  debounce_time,
	input  logic [CFG_W-1:0]  long_press_time,
	output entry_t            nxt,
	output event_t            ev
);

	logic              changed;
	logic [TIME_W-1:0] change_time;
	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] since_press;
	logic              stable;
	logic              held;

	// Elapsed times, wrapping
	assign changed      = raw_pressed != cur.last_raw;
	assign change_time  = changed ? now_ms : cur.last_change;
	assign since_change = now_ms - change_time;
	assign since_press  = now_ms - cur.press_start;
	assign stable       = since_change >= TIME_W'(debounce_time);
	assign held         = since_press >= TIME_W'(long_press_time);

	// Advance the state and pick the event
	always_comb begin
		nxt             = cur;
		nxt.last_raw    = raw_pressed;
		nxt.last_change = change_time;
		ev.valid        = 1'b0;
		ev.action       = ACT_PRESSED;
		if (stable) begin
			priority if (raw_pressed && !cur.debounced) begin
				nxt.debounced   = 1'b1;
				nxt.press_start = now_ms;
				nxt.long_rep    = 1'b0;
				ev.valid        = 1'b1;
				ev.action       = ACT_PRESSED;
			end else if (raw_pressed && !cur.long_rep) begin
				if (held) begin
					nxt.long_rep = 1'b1;
					ev.valid     = 1'b1;
					ev.action    = ACT_LONG;
				end
			end else if (!raw_pressed && cur.debounced) begin
				nxt.debounced = 1'b0;
				ev.valid      = 1'b1;
				ev.action     = ACT_RELEASED;
			end else begin
				// Hold: stable level with nothing to report
			end
		end
	end

endmodule

// File: src/button_debounce_long_press_unit.sv
// Debounces active-low buttons and reports pressed, long-pressed and released events.
//
// Input stream: one sample of one button per transfer; tdata carries the button index,
// the raw pin level (0 = pressed) and the current millisecond time.
// Output stream: one event per sample that causes one (button and action code);
// samples that cause no event, and samples of buttons past the last, produce nothing.
// Configuration: write debounce_time (index 0) or long_press_time (index 1) with
// cfg_we; write only while no sample is in flight.
// An event passes through the update stage and the output register before it is
// presented. Throughput: one sample per cycle unless the output stalls, set by the
// single read-modify-write of the per-button state memory; a write-to-read bypass
// lets the same button follow at once.
// Reset: configuration returns to 20 ms and 500 ms; per-entry valid bits make every
// button read as released, with no clearing pass.
// Stall: when the output register is full and not taken, the update stage holds and
// s_axis_tready falls until the event is transferred.
`include "assert_macros.svh"

module button_debounce_long_press_unit
	import bdlp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [3:0] button_index, [4] pin_level, [36:5] now_ms, [39:37] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [3:0] event_button, [5:4] event_action, [7:6] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	logic [IDX_W-1:0]  in_button;
	logic              in_level;
	logic [TIME_W-1:0] in_now;
	logic              in_fire;

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] long_press_q;

	logic              valid_s1;
	logic              hit_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [IDX_W-1:0]  button_s1;
	logic              raw_s1;
	logic [TIME_W-1:0] now_s1;
	logic              adv_s1;

	entry_t cur_entry;
	entry_t nxt_entry;
	event_t ev;
	event_t ev_s1;
	logic   wr_en;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_button_q;
	action_t          out_action_q;

	assign in_button = s_axis_tdata[IDX_W-1:0];
	assign in_level  = s_axis_tdata[IDX_W];
	assign in_now    = s_axis_tdata[IDX_W+TIME_W:IDX_W+1];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE:   debounce_q   <= cfg_wdata;
				REG_LONG_PRESS: long_press_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake: update stage advances when the output register can take its result
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign wr_en         = adv_s1 && hit_s1;

	// Update stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Update stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			hit_s1    <= {{(7-IDX_W){1'b0}}, in_button} < 7'(BUTTON_COUNT);
			addr_s1   <= ADDR_W'(in_button);
			button_s1 <= in_button;
			raw_s1    <= !in_level;
			now_s1    <= in_now;
		end
	end

	bdlp_state_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_fire),
		.rd_addr (ADDR_W'(in_button)),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (nxt_entry),
		.rd_data (cur_entry)
	);

	bdlp_update u_update (
		.cur             (cur_entry),
		.raw_pressed     (raw_s1),
		.now_ms          (now_s1),
		.debounce_time   (debounce_q),
		.long_press_time (long_press_q),
		.nxt             (nxt_entry),
		.ev              (ev)
	);

	// Drop events of samples outside the button range
	always_comb begin
		ev_s1       = ev;
		ev_s1.valid = ev.valid && valid_s1 && hit_s1;
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= ev_s1.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (adv_s1 && ev_s1.valid) begin
			out_button_q <= button_s1;
			out_action_q <= ev_s1.action;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-IDX_W-2){1'b0}}, out_action_q, out_button_q};

	// Checks
	`ASSERT_NEXT(a_event_reaches_output, clk, arst_n, adv_s1 && ev_s1.valid, m_axis_tvalid)
	`ASSERT_IMPLIES(a_event_needs_item, clk, arst_n, ev_s1.valid, valid_s1 && hit_s1)
	`ASSERT_IMPLIES(a_long_needs_press, clk, arst_n, ev_s1.valid && ev_s1.action == ACT_LONG, cur_entry.debounced)
	`ASSERT_IMPLIES(a_write_needs_advance, clk, arst_n, wr_en, valid_s1 && (!out_valid_q || m_axis_tready))

endmodule

// File: tb/debounce_sb_pkg.sv
// Event scoreboard and per-button predictor for the debounce and long-press unit
`timescale 1ns / 1ps

package debounce_sb_pkg;
	import bdlp_pkg::*;

	// One expected or observed event
	typedef struct packed {
		logic [IDX_W-1:0] button;
		action_t          action;
	} button_event_t;

	class debounce_scoreboard;
		bit                debounced   [BUTTON_COUNT];
		bit                raw_pressed [BUTTON_COUNT];
		bit [TIME_W-1:0]   change_ms   [BUTTON_COUNT];
		bit [TIME_W-1:0]   press_ms    [BUTTON_COUNT];
		bit                long_done   [BUTTON_COUNT];
		bit [CFG_W-1:0]    debounce_len;
		bit [CFG_W-1:0]    long_ms;
		button_event_t     pending_events[$];
		int                errors;

		function new();
			debounce_len = DEBOUNCE_RESET;
			long_ms = LONG_PRESS_RESET;
			errors = 0;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				debounced[i] = 1'b0;
				raw_pressed[i] = 1'b1;
				change_ms[i] = '0;
				press_ms[i] = '0;
				long_done[i] = 1'b0;
			end
		endfunction

		function void set_register(cfg_reg_t idx, bit [CFG_W-1:0] value);
			case (idx)
				REG_DEBOUNCE: begin
					debounce_len = value;
				end
				REG_LONG_PRESS: begin
					long_ms = value;
				end
				default: begin
				end
			endcase
		endfunction

		function void push_event(bit [IDX_W-1:0] b, action_t act);
			button_event_t ev;
			ev.button = b;
			ev.action = act;
			pending_events.push_back(ev);
		endfunction

		// Advance one button's state for an accepted sample and queue any event
		function void note_sample(bit [IDX_W-1:0] b, bit level, bit [TIME_W-1:0] now);
			bit              pressed;
			bit [TIME_W-1:0] stable;
			bit [TIME_W-1:0] held;
			pressed = (level == 1'b0);
			if (b >= BUTTON_COUNT)
				return;
			if (pressed != raw_pressed[b]) begin
				raw_pressed[b] = pressed;
				change_ms[b] = now;
			end
			stable = now - change_ms[b];
			if (stable < {16'd0, debounce_len})
				return;
			held = now - press_ms[b];
			if (pressed && !debounced[b]) begin
				debounced[b] = 1'b1;
				press_ms[b] = now;
				long_done[b] = 1'b0;
				push_event(b, ACT_PRESSED);
			end else if (pressed && !long_done[b]) begin
				if (held >= {16'd0, long_ms}) begin
					long_done[b] = 1'b1;
					push_event(b, ACT_LONG);
				end
			end else if (!pressed && debounced[b]) begin
				debounced[b] = 1'b0;
				push_event(b, ACT_RELEASED);
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("MISMATCH: %s", msg);
		endtask

		// Compare an observed event with the oldest one queued
		task check_event(bit [IDX_W-1:0] b, bit [1:0] act);
			button_event_t want;
			if (pending_events.size() == 0) begin
				report($sformatf("event button %0d action %0d with none queued", b, act));
			end else begin
				want = pending_events.pop_front();
				if (b != want.button)
					report($sformatf("button %0d, want %0d", b, want.button));
				if (act != want.action)
					report($sformatf("button %0d action %0d, want %s", b, act,
						want.action.name()));
			end
		endtask
	endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench of the button debounce and long-press unit
`timescale 1ns / 1ps

module tb_top;
	import bdlp_pkg::*;
	import debounce_sb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [3:0] button_index, [4] pin_level, [36:5] now_ms, [39:37] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [3:0] event_button, [5:4] event_action, [7:6] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	debounce_scoreboard    sb;
	int                    src_idle_pct = 0;
	int                    snk_idle_pct = 0;
	bit                    hold_req = 1'b0;
	int                    hold_left = 0;
	int                    quiet_cycles = 0;
	bit [TIME_W-1:0]       clock_ms = 32'd1000;
	bit                    stim_level [BUTTON_COUNT];
	bit [IDX_W-1:0]        busy_buttons [4];

	button_debounce_long_press_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one sample, idling at random first; return at the edge of its transfer
	task send_sample(input bit [IDX_W-1:0] b, input bit level, input bit [TIME_W-1:0] t);
		bit done;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, t, level, b};
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			if (s_axis_tready) begin
				done = 1'b1;
				sb.note_sample(b, level, t);
			end
			@(posedge clk);
		end
	endtask

	// Drop valid and wait until every queued event is out and the pipeline is empty
	task settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task write_register(input cfg_reg_t idx, input bit [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	// Mostly held and bouncing levels on a few buttons, with some noise and time jumps
	task run_random(input int count);
		int             pick;
		int             step_max;
		bit [IDX_W-1:0] b;
		step_max = (int'(sb.debounce_len) + int'(sb.long_ms)) / 8 + 1;
		for (int k = 0; k < 4; k++)
			busy_buttons[k] = IDX_W'($urandom_range(0, BUTTON_COUNT - 1));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				b = busy_buttons[$urandom_range(0, 3)];
				if ($urandom_range(0, 9) == 0)
					stim_level[b] = ~stim_level[b];
				clock_ms += $urandom_range(0, step_max);
				send_sample(b, stim_level[b], clock_ms);
			end else if (pick < 93) begin
				send_sample(IDX_W'($urandom_range(0, BUTTON_COUNT - 1)),
					1'($urandom_range(0, 1)), clock_ms);
			end else begin
				clock_ms = $urandom;
				b = IDX_W'($urandom_range(0, BUTTON_COUNT - 1));
				send_sample(b, stim_level[b], clock_ms);
			end
		end
	endtask

	task run_phase(input bit [CFG_W-1:0] deb, input bit [CFG_W-1:0] lng,
		input int src_pct, input int snk_pct, input int count);
		settle();
		write_register(REG_DEBOUNCE, deb);
		write_register(REG_LONG_PRESS, lng);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		run_random(count);
	endtask

	// Receiver: random back-pressure, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	// Check each event transfer against the predictor
	always @(negedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_event(m_axis_tdata[3:0], m_axis_tdata[5:4]);
	end

	// Watchdog: end the run after too many cycles with no transfer on either side
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin
		sb = new();
		for (int i = 0; i < BUTTON_COUNT; i++)
			stim_level[i] = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset timings, press, long press, bounce, release
		send_sample(4'd0, 1'b0, 32'd0);
		send_sample(4'd0, 1'b0, 32'd25);
		send_sample(4'd0, 1'b0, 32'd524);
		send_sample(4'd0, 1'b0, 32'd525);
		send_sample(4'd0, 1'b0, 32'd900);
		send_sample(4'd0, 1'b1, 32'd901);
		send_sample(4'd0, 1'b0, 32'd905);
		send_sample(4'd0, 1'b1, 32'd906);
		send_sample(4'd0, 1'b1, 32'd926);
		send_sample(4'd0, 1'b1, 32'd2000);
		// Directed: elapsed times across the wrap of the millisecond clock
		send_sample(4'd15, 1'b0, 32'hFFFF_FFF0);
		send_sample(4'd15, 1'b0, 32'h0000_01E4);
		send_sample(4'd15, 1'b1, 32'hFFFF_FFFF);
		send_sample(4'd15, 1'b1, 32'h0000_0013);
		// Directed: zero debounce and zero long-press time
		settle();
		write_register(REG_DEBOUNCE, 16'd0);
		write_register(REG_LONG_PRESS, 16'd0);
		send_sample(4'd7, 1'b1, 32'd100);
		send_sample(4'd7, 1'b0, 32'd100);
		send_sample(4'd7, 1'b0, 32'd100);
		send_sample(4'd7, 1'b1, 32'd101);

		// Random phases over several timing settings and idling patterns
		run_phase(DEBOUNCE_RESET, LONG_PRESS_RESET, 32, 56, 92);
		run_phase(16'd0, 16'd0, 32, 56, 92);
		settle();
		clock_ms = 32'hFFFF_0000;
		hold_req = 1'b1;
		run_phase(16'hFFFF, 16'hFFFF, 56, 32, 92);
		run_phase(CFG_W'($urandom_range(0, 200)), CFG_W'($urandom_range(0, 2000)), 56, 32, 92);
		run_phase(16'd1, 16'hFFFF, 0, 0, 92);
		run_phase(16'hFFFF, 16'd0, 0, 0, 92);

		settle();
		if (sb.pending_events.size() != 0)
			sb.report($sformatf("%0d events never arrived", sb.pending_events.size()));
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
